@@ design/dtc_pkg.sv @@
// dtc_pkg: shared types and constants for the decimating trace capture block
// holds command codes, transaction structs and sizing constants
// no dependencies
package dtc_pkg;

    localparam int NUM_CHANNELS  = 7;
    localparam int DATA_W        = 32;
    localparam int ROW_FIELD_W   = 7;
    localparam int CHAN_FIELD_W  = 3;
    localparam int COUNT_W       = 16;
    localparam int ROW_DEPTH_DEF = 128;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // register indexes, byte address is 4 * index
    localparam logic REG_RECORD_MODE   = 1'b0;
    localparam logic REG_SAMPLE_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_ARM    = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ARM_OFF        = 3'b001,
        ARM_ONE_SHOT   = 3'b010,
        ARM_CONTINUOUS = 3'b100
    } arm_state_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [DATA_W-1:0] chan0_data;
        logic signed [DATA_W-1:0] chan1_data;
        logic signed [DATA_W-1:0] chan2_data;
        logic signed [DATA_W-1:0] chan3_data;
        logic signed [DATA_W-1:0] chan4_data;
        logic signed [DATA_W-1:0] chan5_data;
        logic signed [DATA_W-1:0] chan6_data;
        logic [CHAN_FIELD_W-1:0]  read_channel;
        logic [ROW_FIELD_W-1:0]   read_row;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic                     armed;
        logic                     writing;
        logic [ROW_FIELD_W-1:0]   row_pointer;
    } result_t;

endpackage

@@ design/dtc_ram.sv @@
// dtc_ram: generic simple dual-port ram, one write port, one registered read port
// used for the per-channel capture rows of the trace block
// no dependencies
module dtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/decimating_trace_capture.sv @@
// decimating_trace_capture: seven-channel decimating trace recorder, top level
// depends on dtc_pkg for types and constants and on dtc_ram for row storage
//
//   channel   handshake                 payload              direction
//   item      item_valid / item_stall   item   (item_t)      into block
//   result    result_valid / result_st. result (result_t)    out of block
//   config    apb psel/penable/pwrite   paddr[2:0], pwdata   into block
//
// one transaction per clock when the result side does not stall; each result passes through
// the registered ram read and then the result register
// state (arm, counter, row) updates at the accept edge, so the next transaction sees it
// a stalled result holds; one more transaction waits in the read stage, then item_stall rises
// rst_n clears control state only; ram contents stay undefined until written
module decimating_trace_capture #(
    parameter int ROW_DEPTH = dtc_pkg::ROW_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  dtc_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output dtc_pkg::result_t                  result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dtc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dtc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dtc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int RW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int PW = (RW > dtc_pkg::ROW_FIELD_W) ? RW : dtc_pkg::ROW_FIELD_W;
    localparam logic [RW-1:0] ROW_LAST = RW'(ROW_DEPTH - 1);

    // configuration registers
    logic                            record_mode_reg;
    logic [dtc_pkg::COUNT_W-1:0]     sample_period_reg;
    logic                            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_mode_reg   <= 1'b0;
            sample_period_reg <= dtc_pkg::COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                dtc_pkg::REG_RECORD_MODE:   record_mode_reg   <= pwdata[0];
                dtc_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[dtc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            dtc_pkg::REG_RECORD_MODE:
                prdata = {{(dtc_pkg::APB_DATA_W-1){1'b0}}, record_mode_reg};
            dtc_pkg::REG_SAMPLE_PERIOD:
                prdata = {{(dtc_pkg::APB_DATA_W-dtc_pkg::COUNT_W){1'b0}}, sample_period_reg};
            default:
                prdata = '0;
        endcase
    end

    // recorder control state
    dtc_pkg::arm_state_t             arm_state_reg, arm_state_next;
    logic                            write_en_reg, write_en_next;
    logic [dtc_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [RW-1:0]                   row_reg, row_next;

    // pipeline: read stage (ram data register) then result register
    logic                            s1_valid_reg;
    logic                            s1_read_reg;
    logic [dtc_pkg::CHAN_FIELD_W-1:0] s1_chan_reg;
    logic                            s1_armed_reg;
    logic                            s1_writing_reg;
    logic [dtc_pkg::ROW_FIELD_W-1:0] s1_row_reg;
    logic                            out_valid_reg;
    dtc_pkg::result_t                out_reg, out_next;

    logic                            s1_move;
    logic                            accept;
    logic                            store_row;
    logic [dtc_pkg::COUNT_W-1:0]     count_inc;
    logic [RW-1:0]                   row_adv;
    logic [RW-1:0]                   rd_addr;
    logic [PW-1:0]                   row_wide;
    logic [dtc_pkg::DATA_W-1:0]      chan_word [dtc_pkg::NUM_CHANNELS];
    logic [dtc_pkg::DATA_W-1:0]      ram_rdata [dtc_pkg::NUM_CHANNELS];

    assign s1_move    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_move;
    assign accept     = item_valid && !item_stall;

    assign count_inc = count_reg + dtc_pkg::COUNT_W'(1);
    assign row_adv   = (row_reg == ROW_LAST) ? '0 : row_reg + RW'(1);

    always_comb
    begin
        arm_state_next = arm_state_reg;
        write_en_next  = write_en_reg;
        count_next     = count_reg;
        row_next       = row_reg;
        store_row      = 1'b0;
        case (item.cmd)
            dtc_pkg::CMD_SAMPLE:
            begin
                if (arm_state_reg != dtc_pkg::ARM_OFF)
                begin
                    count_next = count_inc;
                    if (count_inc == sample_period_reg)
                    begin
                        count_next = '0;
                        store_row  = write_en_reg;
                        row_next   = row_adv;
                        // one-shot writing ends when the row pointer wraps
                        if (row_adv == '0 && arm_state_reg == dtc_pkg::ARM_ONE_SHOT)
                        begin
                            write_en_next = 1'b0;
                        end
                    end
                end
            end
            dtc_pkg::CMD_ARM:
            begin
                if (arm_state_reg == dtc_pkg::ARM_OFF)
                begin
                    arm_state_next = record_mode_reg ? dtc_pkg::ARM_CONTINUOUS
                                                     : dtc_pkg::ARM_ONE_SHOT;
                    write_en_next  = 1'b1;
                    // preload so the first sample after arm is stored
                    count_next     = sample_period_reg - dtc_pkg::COUNT_W'(1);
                end
            end
            dtc_pkg::CMD_STOP:
            begin
                arm_state_next = dtc_pkg::ARM_OFF;
                write_en_next  = 1'b0;
                row_next       = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_state_reg <= dtc_pkg::ARM_OFF;
            write_en_reg  <= 1'b0;
            count_reg     <= '0;
            row_reg       <= '0;
        end
        else if (accept)
        begin
            arm_state_reg <= arm_state_next;
            write_en_reg  <= write_en_next;
            count_reg     <= count_next;
            row_reg       <= row_next;
        end
    end

    // read row taken modulo the row depth
    generate
        if (ROW_DEPTH >= (1 << dtc_pkg::ROW_FIELD_W))
        begin : g_addr_direct
            assign rd_addr = RW'(item.read_row);
        end
        else
        begin : g_addr_mod
            localparam int RECIP = (1 << 14) / ROW_DEPTH;
            logic [20:0] prod;
            logic [6:0]  quot;
            logic [13:0] back;
            logic [7:0]  rem;
            assign prod = 21'(item.read_row) * 21'(RECIP);
            assign quot = prod[20:14];
            assign back = 14'(quot) * 14'(ROW_DEPTH);
            assign rem  = {1'b0, item.read_row} - back[7:0];
            // reciprocal estimate may fall one short
            assign rd_addr = (rem >= 8'(ROW_DEPTH)) ? RW'(rem - 8'(ROW_DEPTH)) : RW'(rem);
        end
    endgenerate

    assign chan_word[0] = item.chan0_data;
    assign chan_word[1] = item.chan1_data;
    assign chan_word[2] = item.chan2_data;
    assign chan_word[3] = item.chan3_data;
    assign chan_word[4] = item.chan4_data;
    assign chan_word[5] = item.chan5_data;
    assign chan_word[6] = item.chan6_data;

    generate
        for (genvar ch = 0; ch < dtc_pkg::NUM_CHANNELS; ch++)
        begin : g_chan_ram
            dtc_ram #(
                .WIDTH (dtc_pkg::DATA_W),
                .DEPTH (ROW_DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (accept && store_row),
                .waddr (row_reg),
                .wdata (chan_word[ch]),
                .re    (accept && item.cmd == dtc_pkg::CMD_READ),
                .raddr (rd_addr),
                .rdata (ram_rdata[ch])
            );
        end
    endgenerate

    assign row_wide = PW'(row_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg    <= (item.cmd == dtc_pkg::CMD_READ);
            s1_chan_reg    <= item.read_channel;
            s1_armed_reg   <= (arm_state_next != dtc_pkg::ARM_OFF);
            s1_writing_reg <= write_en_next;
            s1_row_reg     <= row_wide[dtc_pkg::ROW_FIELD_W-1:0];
        end
    end

    always_comb
    begin
        out_next.read_data   = '0;
        out_next.armed       = s1_armed_reg;
        out_next.writing     = s1_writing_reg;
        out_next.row_pointer = s1_row_reg;
        for (int i = 0; i < dtc_pkg::NUM_CHANNELS; i++)
        begin
            if (s1_read_reg && s1_chan_reg == dtc_pkg::CHAN_FIELD_W'(i))
            begin
                out_next.read_data = ram_rdata[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // writing is only ever enabled while armed
    a_write_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        write_en_reg |-> arm_state_reg != dtc_pkg::ARM_OFF)
        else $error("write enable set while disarmed");

    // a stop transaction leaves the recorder disarmed at row zero
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.cmd == dtc_pkg::CMD_STOP
        |=> row_reg == '0 && arm_state_reg == dtc_pkg::ARM_OFF && !write_en_reg)
        else $error("stop did not clear recorder state");

    // input side only stalls when the read stage holds a transaction that cannot move
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && out_valid_reg && result_stall)
        else $error("input stalled with room in the pipeline");

endmodule
